// ----- rtl/core/tlbr_pkg.sv -----
package tlbr_pkg;

    localparam int PAGE_W = 20;
    localparam int OFF_W  = 12;
    localparam int LFSR_W = 16;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_ONE  = 16'h0001;

    // One item travelling down the cell row
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [PAGE_W-1:0] key;
    } tlbr_link_t;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] sh;
        sh = s >> 1;
        if (s[0])
        begin
            sh = sh ^ LFSR_TAPS;
        end
        return sh;
    endfunction

endpackage

// ----- rtl/core/tlb_lookup_random_replace_unit.sv -----
// Channel   Signals                               Direction  Item
// --------  ------------------------------------  ---------  ------------------------------
// in        in_valid, in_ready, virtual_address   input      one address to look up
// out       out_valid, out_ready, page_number,    output     page, offset and hit flag
//           page_offset, tlb_hit
// cfg       cfg_wr_en, cfg_wr_data                input      LFSR seed, zero loads as one
//
// An item walks the row of ENTRIES tag cells, one cell per cycle, while the
// victim index (next LFSR value mod ENTRIES) is worked out by a reciprocal
// multiply, hidden under the walk. One item is in flight at a time: it
// passes the cell row, the tail registers and the output register, and the
// next item is accepted once it has committed.
// Reset empties the TLB (fill count zero) and sets the LFSR to one.
// A finished item waits in the output register; a new item may be accepted
// meanwhile, but its commit waits until the output register is free.
module tlb_lookup_random_replace_unit
    import tlbr_pkg::*;
#(
    parameter int ENTRIES     = 8,
    parameter int OFFSET_BITS = 12,
    parameter int ADDR_BITS   = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADDR_BITS-1:0]  virtual_address,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PAGE_W-1:0]     page_number,
    output logic [OFF_W-1:0]      page_offset,
    output logic                  tlb_hit,

    input  logic                  cfg_wr_en,
    input  logic [LFSR_W-1:0]     cfg_wr_data
);

    localparam int FW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [63:0] OFF_MASK = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam logic [FW-1:0] FULL = FW'(ENTRIES);

    // ---- control and item state ----
    logic              busy_reg;
    logic              tail_done_reg;
    logic              tail_hit_reg;
    logic [FW-1:0]     fill_reg;
    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] cand_reg;      // LFSR value if this item replaces
    logic [PAGE_W-1:0] page_reg;
    logic [OFF_W-1:0]  off_reg;

    logic              out_valid_reg;
    logic [PAGE_W-1:0] out_page_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic              out_hit_reg;

    logic              accept;
    logic              commit;
    logic              miss;
    logic              full;
    logic [63:0]       addr_ext;
    logic [PAGE_W-1:0] page_in;
    logic [OFF_W-1:0]  off_in;
    logic [LFSR_W-1:0] cand_next;
    logic              rem_done;
    logic [IW-1:0]     victim;
    logic [IW-1:0]     wr_index;

    tlbr_link_t        link_chain [ENTRIES+1];

    assign in_ready = !busy_reg;
    assign accept   = in_valid & in_ready;

    // Split the address. Shifting the zero-extended word gives a zero page
    // when the offset covers the whole address.
    assign addr_ext = 64'(virtual_address);
    assign page_in  = PAGE_W'(addr_ext >> OFFSET_BITS);
    assign off_in   = OFF_W'(addr_ext & OFF_MASK);

    assign cand_next = lfsr_next(lfsr_reg);

    // Head of the cell row: the new item enters with no hit yet
    assign link_chain[0].vld = accept;
    assign link_chain[0].hit = 1'b0;
    assign link_chain[0].key = page_in;

    // Commit once the walk has left the last cell, the victim is known and the output is free
    assign commit = busy_reg & tail_done_reg & rem_done & (!out_valid_reg | out_ready);
    assign miss   = !tail_hit_reg;
    assign full   = (fill_reg == FULL);

    // Fill in order while slots remain, then take the random victim
    assign wr_index = full ? victim : IW'(fill_reg);

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            logic slot_valid;
            logic wr_en;

            assign slot_valid = (FW'(gi) < fill_reg);
            assign wr_en      = commit & miss & (wr_index == IW'(gi));

            tlbr_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .slot_valid (slot_valid),
                .link_in    (link_chain[gi]),
                .link_out   (link_chain[gi+1]),
                .wr_en      (wr_en),
                .wr_tag     (page_reg)
            );
        end
    endgenerate

    // Victim slot: candidate LFSR value modulo ENTRIES, from the product and remainder registers
    tlbr_mod #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .value (cand_next),
        .done  (rem_done),
        .rem   (victim)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            tail_done_reg <= 1'b0;
            fill_reg      <= '0;
            lfsr_reg      <= LFSR_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end

            if (link_chain[ENTRIES].vld)
            begin
                tail_done_reg <= 1'b1;
            end
            else if (commit)
            begin
                tail_done_reg <= 1'b0;
            end

            // seed writes must only arrive while idle; the block itself does not enforce this
            if (cfg_wr_en)
            begin
                lfsr_reg <= (cfg_wr_data != '0) ? cfg_wr_data : LFSR_ONE;
            end
            else if (commit & miss & full)
            begin
                lfsr_reg <= cand_reg;
            end

            if (commit & miss & !full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= page_in;
            off_reg  <= off_in;
            cand_reg <= cand_next;
        end
        if (link_chain[ENTRIES].vld)
        begin
            tail_hit_reg <= link_chain[ENTRIES].hit;
        end
        if (commit)
        begin
            out_page_reg <= page_reg;
            out_off_reg  <= off_reg;
            out_hit_reg  <= tail_hit_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign page_number = out_page_reg;
    assign page_offset = out_off_reg;
    assign tlb_hit     = out_hit_reg;

endmodule

// ----- rtl/core/tlbr_cell.sv -----
module tlbr_cell
    import tlbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              slot_valid,
    input  tlbr_link_t        link_in,
    output tlbr_link_t        link_out,
    input  logic              wr_en,
    input  logic [PAGE_W-1:0] wr_tag
);

    logic [PAGE_W-1:0] tag_reg;
    logic              vld_reg;
    logic              hit_reg;
    logic [PAGE_W-1:0] key_reg;
    logic              hit_next;

    // tag only compared once the slot has been filled
    assign hit_next = link_in.hit | (slot_valid & (tag_reg == link_in.key));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= link_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        key_reg <= link_in.key;
        if (wr_en)
        begin
            tag_reg <= wr_tag;
        end
    end

    assign link_out.vld = vld_reg;
    assign link_out.hit = hit_reg;
    assign link_out.key = key_reg;

endmodule

// ----- rtl/core/tlbr_mod.sv -----
module tlbr_mod
    import tlbr_pkg::*;
#(
    parameter int ENTRIES = 8,
    parameter int IW      = 3
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [LFSR_W-1:0]         value,
    output logic                      done,
    output logic [IW-1:0]             rem
);

    // floor(v / ENTRIES) == (v * RECIP) >> SH for every 16-bit v
    localparam int SH = LFSR_W + $clog2(ENTRIES);
    localparam int MW = LFSR_W + 2;
    localparam int PW = LFSR_W + MW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) / 64'(ENTRIES)) + 64'd1);
    localparam logic [LFSR_W-1:0] DIVISOR = LFSR_W'(ENTRIES);

    logic              pend_reg;
    logic [LFSR_W-1:0] val_reg;
    logic [PW-1:0]     prod_reg;
    logic [IW-1:0]     rem_reg;
    logic [LFSR_W-1:0] quo;
    logic [LFSR_W-1:0] back;
    logic [LFSR_W-1:0] diff;

    // from the product register: quotient back out, remainder is what is left
    assign quo  = LFSR_W'(prod_reg >> SH);
    assign back = quo * DIVISOR;
    assign diff = val_reg - back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            prod_reg <= PW'(value) * PW'(RECIP);
        end
        if (pend_reg)
        begin
            rem_reg <= IW'(diff);
        end
    end

    assign done = !pend_reg;
    assign rem  = rem_reg;

endmodule

// ----- bench/tb_tlb_lookup_random_replace_unit.sv -----
`timescale 1ns / 1ps

module tb_tlb_lookup_random_replace_unit;
    import tlbr_pkg::*;

    localparam int ENTRIES     = 8;
    localparam int OFFSET_BITS = 12;
    localparam int ADDR_BITS   = 32;

    // Margin that outlasts the row walk and commit
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_GAP       = 30;
    localparam int POOL_PAGES    = 12;

    typedef struct {
        logic [PAGE_W-1:0] page;
        logic [OFF_W-1:0]  offset;
        logic              hit;
    } translation_t;

    // Shadow copy of the TLB: tags, fill count and replacement LFSR.
    // Every accepted address is translated here and the translation waits
    // in order for the block's result.
    class tlb_shadow;
        logic [PAGE_W-1:0] tags [ENTRIES];
        int                fill;
        logic [LFSR_W-1:0] rnd;
        translation_t      awaited [$];
        int                errors;

        function new();
            fill   = 0;
            rnd    = LFSR_ONE;
            errors = 0;
        endfunction

        // zero would lock the generator, so it loads as one
        function void load_seed(logic [LFSR_W-1:0] seed);
            rnd = (seed == '0) ? LFSR_ONE : seed;
        endfunction

        function void record_lookup(logic [ADDR_BITS-1:0] addr);
            translation_t t;
            logic         found;
            logic         lsb;
            t.page   = addr[ADDR_BITS-1:OFFSET_BITS];
            t.offset = addr[OFFSET_BITS-1:0];
            found    = 1'b0;
            for (int i = 0; i < fill; i++)
            begin
                if (tags[i] == t.page)
                    found = 1'b1;
            end
            if (!found)
            begin
                if (fill < ENTRIES)
                begin
                    tags[fill] = t.page;
                    fill++;
                end
                else
                begin
                    // Galois step, then victim = new value mod entry count
                    lsb = rnd[0];
                    rnd = rnd >> 1;
                    if (lsb)
                        rnd = rnd ^ LFSR_TAPS;
                    tags[rnd % ENTRIES] = t.page;
                end
            end
            t.hit = found;
            awaited.push_back(t);
        endfunction

        function void check_result(logic [PAGE_W-1:0] pn, logic [OFF_W-1:0] po, logic hit);
            translation_t t;
            if (awaited.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual page %h offset %h hit %b",
                         $time, pn, po, hit);
                errors++;
                return;
            end
            t = awaited.pop_front();
            if (pn !== t.page)
            begin
                $display("%0t page_number: expected %h actual %h", $time, t.page, pn);
                errors++;
            end
            if (po !== t.offset)
            begin
                $display("%0t page_offset: expected %h actual %h", $time, t.offset, po);
                errors++;
            end
            if (hit !== t.hit)
            begin
                $display("%0t tlb_hit: expected %b actual %b", $time, t.hit, hit);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ADDR_BITS-1:0] virtual_address = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PAGE_W-1:0]    page_number;
    logic [OFF_W-1:0]     page_offset;
    logic                 tlb_hit;
    logic                 cfg_wr_en = 1'b0;
    logic [LFSR_W-1:0]    cfg_wr_data = '0;

    // percent of cycles in which each side holds off
    int send_idle_pct = 22;
    int take_idle_pct = 79;

    tlb_shadow shadow = new();

    tlb_lookup_random_replace_unit #(
        .ENTRIES     (ENTRIES),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .virtual_address (virtual_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .page_number     (page_number),
        .page_offset     (page_offset),
        .tlb_hit         (tlb_hit),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    initial
    begin
        forever
            #10 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: values sampled here are those seen at the edge, since
    // the block's own updates land later in the step.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.check_result(page_number, page_offset, tlb_hit);
        out_ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end

    // Present one address and hold it until taken. valid is lowered only
    // when a gap is actually inserted, so it never drops and rises in one step.
    task automatic send_address(input logic [ADDR_BITS-1:0] addr);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        virtual_address <= addr;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.record_lookup(addr);
    endtask

    // Seed writes only when the block has gone quiet
    task automatic write_seed(input logic [LFSR_W-1:0] seed);
        in_valid <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow.load_seed(seed);
    endtask

    // Mostly pages from a pool a bit larger than the TLB, so hits, fills
    // and random evictions all happen; the rest are unrestricted addresses.
    task automatic run_random(input int count);
        logic [PAGE_W-1:0]    pool [POOL_PAGES];
        logic [ADDR_BITS-1:0] addr;
        foreach (pool[i])
            pool[i] = PAGE_W'($urandom());
        pool[0] = '0;
        pool[1] = '1;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 80)
                addr = {pool[$urandom_range(0, POOL_PAGES - 1)], OFF_W'($urandom())};
            else
                addr = $urandom();
            send_address(addr);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Phase 1: top seed, sender mostly busy, receiver mostly stalling
        write_seed(16'hFFFF);

        // empty TLB: miss, then hit on the same page from the other offset extreme
        send_address(32'h0000_0000);
        send_address(32'h0000_0FFF);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_F000);
        // fill the remaining slots
        send_address(32'h0000_1ABC);
        send_address(32'h0000_2001);
        send_address(32'h0000_3FFE);
        send_address(32'h0000_4800);
        send_address(32'h0000_5123);
        send_address(32'h0000_6456);
        // full TLB: a hit, then misses that force random replacement
        send_address(32'h0000_1000);
        send_address(32'h8000_0000);
        send_address(32'h4000_0FFF);
        send_address(32'h5555_5AAA);
        send_address(32'hAAAA_A555);
        send_address(32'h7FFF_F7FF);
        // revisit: some pages survived, some were evicted
        send_address(32'h0000_0123);
        send_address(32'hFFFF_F800);
        send_address(32'h0000_3000);
        send_address(32'h8000_0001);
        send_address(32'h5555_5000);

        run_random(267);

        // Phase 2: zero seed (loads as one), roles swapped
        write_seed(16'h0000);
        send_idle_pct = 79;
        take_idle_pct = 22;
        run_random(267);

        // Phase 3: arbitrary seed, full throughput both sides
        write_seed(LFSR_W'($urandom_range(2, 16'hFFFE)));
        send_idle_pct = 0;
        take_idle_pct = 0;
        run_random(267);

        in_valid <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (shadow.errors == 0 && shadow.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tlbr_pkg.sv
rtl/core/tlbr_cell.sv
rtl/core/tlbr_mod.sv
rtl/core/tlb_lookup_random_replace_unit.sv
bench/tb_tlb_lookup_random_replace_unit.sv
